FILE: hdl/bmmd_pkg.sv
// Shared types, target codes and address constants for the banked memory map decoder.
package bmmd_pkg;

  // Target codes
  localparam logic [2:0] TGT_ROM   = 3'd0;
  localparam logic [2:0] TGT_CRAM  = 3'd1;
  localparam logic [2:0] TGT_INT   = 3'd2;
  localparam logic [2:0] TGT_NONE  = 3'd3;
  localparam logic [2:0] TGT_DMA   = 3'd4;
  localparam logic [2:0] TGT_TIMER = 3'd5;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Address map boundaries
  localparam logic [15:0] ADDR_ECHO_LO  = 16'hE000;
  localparam logic [15:0] ADDR_ECHO_HI  = 16'hFE00;
  localparam logic [15:0] ECHO_OFFSET   = 16'h2000;
  localparam logic [15:0] ADDR_UNUSE_LO = 16'hFEA0;
  localparam logic [15:0] ADDR_UNUSE_HI = 16'hFEFF;
  localparam logic [15:0] ADDR_LY       = 16'hFF44;
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_TAC      = 16'hFF07;
  localparam logic [3:0]  GATE_KEY      = 4'hA;

  // Register-space write selectors, address bits 14..13 below 0x8000
  localparam logic [1:0] REG_GATE    = 2'd0;
  localparam logic [1:0] REG_ROM_LO  = 2'd1;
  localparam logic [1:0] REG_UPPER   = 2'd2;
  localparam logic [1:0] REG_MODE    = 2'd3;

  localparam logic [6:0] ROM_BANK_RESET = 7'd1;

  typedef struct packed {
    logic [6:0] rom_bank_sel;
    logic [1:0] ram_bank_sel;
    logic       ram_banking_mode;
    logic       ram_gate;
  } bank_t;

  typedef struct packed {
    logic        func;
    logic [15:0] address;
    logic [7:0]  data_in;
  } access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [20:0] phys_address;
    logic [7:0]  store_byte;
    logic        mirror_write;
    logic [15:0] mirror_address;
    logic        ram_gate_open;
  } result_t;

endpackage

FILE: hdl/bmmd_if.sv
// Valid/ready channel interfaces for bus accesses and decode results.
interface bmmd_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] address;
  logic [7:0]  data_in;

  modport source (output valid, output func, output address, output data_in, input ready);
  modport sink   (input valid, input func, input address, input data_in, output ready);
endinterface

interface bmmd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [20:0] phys_address;
  logic [7:0]  store_byte;
  logic        mirror_write;
  logic [15:0] mirror_address;
  logic        ram_gate_open;

  modport source (output valid, output target, output phys_address, output store_byte,
                  output mirror_write, output mirror_address, output ram_gate_open,
                  input ready);
  modport sink   (input valid, input target, input phys_address, input store_byte,
                  input mirror_write, input mirror_address, input ram_gate_open,
                  output ready);
endinterface

FILE: hdl/bmmd_bank_regs.sv
// Bank-controller state registers: ROM bank, RAM bank, banking mode and RAM gate.
module bmmd_bank_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd_en,
  input  bmmd_pkg::bank_t bank_nxt,
  output bmmd_pkg::bank_t bank_r
);

  // Hold state until a decoded transaction advances into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.rom_bank_sel     <= bmmd_pkg::ROM_BANK_RESET;
      bank_r.ram_bank_sel     <= 2'd0;
      bank_r.ram_banking_mode <= 1'b0;
      bank_r.ram_gate         <= 1'b0;
    end else if (upd_en) begin
      bank_r <= bank_nxt;
    end
  end

endmodule

FILE: hdl/bmmd_decode.sv
// Combinational address decode and bank-register update for one bus access.
module bmmd_decode (
  input  bmmd_pkg::access_t acc,
  input  bmmd_pkg::bank_t   bank,
  output bmmd_pkg::result_t res,
  output bmmd_pkg::bank_t   bank_nxt
);

  logic [15:0] a;
  logic [7:0]  d;
  logic        in_echo;
  logic        in_cram;
  logic        in_unuse;
  logic [4:0]  rom_lo;

  assign a        = acc.address;
  assign d        = acc.data_in;
  assign in_echo  = (a >= bmmd_pkg::ADDR_ECHO_LO) && (a < bmmd_pkg::ADDR_ECHO_HI);
  assign in_cram  = (a[15:13] == 3'b101);
  assign in_unuse = (a >= bmmd_pkg::ADDR_UNUSE_LO) && (a < bmmd_pkg::ADDR_UNUSE_HI);
  assign rom_lo   = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];

  // Decode target and addresses, update bank state on register writes
  always_comb begin
    bank_nxt           = bank;
    res.target         = bmmd_pkg::TGT_INT;
    res.phys_address   = {5'd0, a};
    res.store_byte     = 8'd0;
    res.mirror_write   = 1'b0;
    res.mirror_address = 16'd0;

    if (acc.func == bmmd_pkg::FUNC_READ) begin
      if (a[15] == 1'b0) begin
        res.target = bmmd_pkg::TGT_ROM;
        if (a[14]) begin
          res.phys_address = {bank.rom_bank_sel, a[13:0]};
        end
      end else if (in_cram) begin
        res.target       = bmmd_pkg::TGT_CRAM;
        res.phys_address = {6'd0, bank.ram_bank_sel, a[12:0]};
      end else if (in_echo) begin
        res.phys_address = {5'd0, a - bmmd_pkg::ECHO_OFFSET};
      end
    end else if (a[15] == 1'b0) begin
      res.target       = bmmd_pkg::TGT_NONE;
      res.phys_address = 21'd0;
      case (a[14:13])
        bmmd_pkg::REG_GATE: begin
          bank_nxt.ram_gate = (d[3:0] == bmmd_pkg::GATE_KEY);
        end
        bmmd_pkg::REG_ROM_LO: begin
          bank_nxt.rom_bank_sel[4:0] = rom_lo;
        end
        bmmd_pkg::REG_UPPER: begin
          if (bank.ram_banking_mode) begin
            bank_nxt.ram_bank_sel = d[1:0];
          end else begin
            bank_nxt.rom_bank_sel[6:5] = d[1:0];
          end
        end
        bmmd_pkg::REG_MODE: begin
          bank_nxt.ram_banking_mode = d[0];
        end
        default: begin
          bank_nxt = bank;
        end
      endcase
    end else if (in_unuse) begin
      res.target       = bmmd_pkg::TGT_NONE;
      res.phys_address = 21'd0;
    end else if (in_cram) begin
      res.target       = bmmd_pkg::TGT_CRAM;
      res.phys_address = {6'd0, bank.ram_bank_sel, a[12:0]};
      res.store_byte   = d;
    end else if (in_echo) begin
      res.store_byte     = d;
      res.mirror_write   = 1'b1;
      res.mirror_address = a - bmmd_pkg::ECHO_OFFSET;
    end else if ((a == bmmd_pkg::ADDR_LY) || (a == bmmd_pkg::ADDR_DIV)) begin
      res.store_byte = 8'd0;
    end else if (a == bmmd_pkg::ADDR_DMA) begin
      res.target       = bmmd_pkg::TGT_DMA;
      res.phys_address = {5'd0, d, 8'd0};
      res.store_byte   = d;
    end else if (a == bmmd_pkg::ADDR_TAC) begin
      res.target     = bmmd_pkg::TGT_TIMER;
      res.store_byte = d;
    end else begin
      res.store_byte = d;
    end

    res.ram_gate_open = bank_nxt.ram_gate;
  end

endmodule

FILE: hdl/banked_memory_map_decoder_top.sv
// Top level of the banked memory map decoder: input register, decode, result register.
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------------
//  in_bus    | sink      | func, address, data_in
//  out_bus   | source    | target, phys_address, store_byte, mirror_write,
//            |           | mirror_address, ram_gate_open
//
// One transaction per cycle sustained while out_bus.ready stays high; an accepted access
// passes through the input register and then the result register around the decode
// logic before its result is valid.
// Bank registers update as a transaction moves into the result register, so each access
// sees the state left by the one before it.
// Synchronous active-low reset empties both registers and restores the bank state.
// A stalled result holds the pipeline; in_bus.ready follows out_bus.ready combinationally.
module banked_memory_map_decoder_top (
  input logic        clk,
  input logic        rst_n,
  bmmd_in_if.sink    in_bus,
  bmmd_out_if.source out_bus
);

  logic               in_v_r;
  bmmd_pkg::access_t  in_r;
  logic               out_v_r;
  bmmd_pkg::result_t  out_r;
  logic               advance;
  bmmd_pkg::result_t  res;
  bmmd_pkg::bank_t    bank_r;
  bmmd_pkg::bank_t    bank_nxt;

  assign advance      = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || advance;

  // Capture accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_r.func    <= in_bus.func;
      in_r.address <= in_bus.address;
      in_r.data_in <= in_bus.data_in;
    end
  end

  bmmd_decode u_decode (
    .acc      (in_r),
    .bank     (bank_r),
    .res      (res),
    .bank_nxt (bank_nxt)
  );

  bmmd_bank_regs u_bank_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (advance),
    .bank_nxt (bank_nxt),
    .bank_r   (bank_r)
  );

  // Advance result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_bus.valid          = out_v_r;
  assign out_bus.target         = out_r.target;
  assign out_bus.phys_address   = out_r.phys_address;
  assign out_bus.store_byte     = out_r.store_byte;
  assign out_bus.mirror_write   = out_r.mirror_write;
  assign out_bus.mirror_address = out_r.mirror_address;
  assign out_bus.ram_gate_open  = out_r.ram_gate_open;

endmodule

FILE: tb/tb_banked_memory_map_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the banked memory map decoder top level.
module tb_banked_memory_map_decoder_top;
  import bmmd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 18;
  localparam int SETTLE       = 8;

  // Boundary addresses that sit on either side of a region edge
  localparam logic [15:0] EDGE_ADDRS [16] = '{
    16'h0000, 16'h1FFF, 16'h3FFF, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hC000, 16'hDFFF,
    16'hE000, 16'hFDFF, 16'hFE9F, 16'hFEA0, 16'hFEFE, 16'hFEFF, 16'hFF44, 16'hFF46
  };

  logic clk;
  logic rst_n;

  bmmd_in_if  access_ch ();
  bmmd_out_if result_ch ();

  banked_memory_map_decoder_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (access_ch),
    .out_bus (result_ch)
  );

  // Predicted bank-controller state
  logic [6:0] rom_bank;
  logic [1:0] ram_bank;
  logic       bank_mode;
  logic       ram_enabled;

  result_t pending_decodes [$];
  result_t observed;
  result_t predicted;

  int  cycle_count = 0;
  int  access_count;
  int  write_count;
  int  bank_write_count;
  int  result_count = 0;
  int  mismatch_count = 0;
  bit  steady_flow;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Predict one decode and advance the bank state
  function automatic result_t decode_access(input access_t acc);
    result_t    r;
    logic [4:0] low_bank;
    r.target         = TGT_INT;
    r.phys_address   = 21'(acc.address);
    r.store_byte     = 8'h00;
    r.mirror_write   = 1'b0;
    r.mirror_address = 16'h0000;
    if (acc.func == FUNC_READ) begin
      if (acc.address < 16'h4000) begin
        r.target = TGT_ROM;
      end else if (acc.address < 16'h8000) begin
        r.target       = TGT_ROM;
        r.phys_address = 21'(rom_bank) * 21'h4000 + 21'(acc.address - 16'h4000);
      end else if (acc.address >= 16'hA000 && acc.address < 16'hC000) begin
        r.target       = TGT_CRAM;
        r.phys_address = 21'(ram_bank) * 21'h2000 + 21'(acc.address - 16'hA000);
      end else if (acc.address >= ADDR_ECHO_LO && acc.address < ADDR_ECHO_HI) begin
        r.phys_address = 21'(acc.address - ECHO_OFFSET);
      end
    end else if (acc.address < 16'h8000) begin
      r.target       = TGT_NONE;
      r.phys_address = '0;
      if (acc.address < 16'h2000) begin
        ram_enabled = (acc.data_in[3:0] == GATE_KEY);
      end else if (acc.address < 16'h4000) begin
        low_bank = acc.data_in[4:0];
        if (low_bank == 5'd0) low_bank = 5'd1;
        rom_bank[4:0] = low_bank;
      end else if (acc.address < 16'h6000) begin
        if (bank_mode == 1'b0) rom_bank[6:5] = acc.data_in[1:0];
        else ram_bank = acc.data_in[1:0];
      end else begin
        bank_mode = acc.data_in[0];
      end
    end else if (acc.address >= ADDR_UNUSE_LO && acc.address < ADDR_UNUSE_HI) begin
      r.target       = TGT_NONE;
      r.phys_address = '0;
    end else if (acc.address >= 16'hA000 && acc.address < 16'hC000) begin
      r.target       = TGT_CRAM;
      r.phys_address = 21'(ram_bank) * 21'h2000 + 21'(acc.address - 16'hA000);
      r.store_byte   = acc.data_in;
    end else if (acc.address >= ADDR_ECHO_LO && acc.address < ADDR_ECHO_HI) begin
      r.store_byte     = acc.data_in;
      r.mirror_write   = 1'b1;
      r.mirror_address = acc.address - ECHO_OFFSET;
    end else if (acc.address == ADDR_LY || acc.address == ADDR_DIV) begin
      r.store_byte = 8'h00;
    end else if (acc.address == ADDR_DMA) begin
      r.target       = TGT_DMA;
      r.phys_address = 21'(acc.data_in) << 8;
      r.store_byte   = acc.data_in;
    end else if (acc.address == ADDR_TAC) begin
      r.target     = TGT_TIMER;
      r.store_byte = acc.data_in;
    end else begin
      r.store_byte = acc.data_in;
    end
    r.ram_gate_open = ram_enabled;
    return r;
  endfunction

  // Send one access transaction and queue its predicted decode on acceptance
  task automatic send_access(input logic kind, input logic [15:0] addr, input logic [7:0] data);
    access_t acc;
    acc.func    = kind;
    acc.address = addr;
    acc.data_in = data;
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        access_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    access_ch.valid   <= 1'b1;
    access_ch.func    <= kind;
    access_ch.address <= addr;
    access_ch.data_in <= data;
    @(posedge clk);
    while (!access_ch.ready) @(posedge clk);
    pending_decodes.push_back(decode_access(acc));
    access_count++;
    if (kind == FUNC_WRITE) begin
      write_count++;
      if (addr < 16'h8000) bank_write_count++;
    end
  endtask

  // Drop valid and hold until every queued decode has come back
  task automatic drain_pending();
    access_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // Draw one access, weighted towards bank traffic and region edges
  function automatic access_t pick_access();
    access_t acc;
    acc.func    = logic'($urandom_range(0, 1));
    acc.address = 16'($urandom);
    acc.data_in = 8'($urandom);
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        acc.func    = FUNC_WRITE;
        acc.address = 16'($urandom_range(0, 16'h7FFF));
        if ($urandom_range(0, 1) == 1) acc.data_in[3:0] = GATE_KEY;
      end
      3, 4: begin
        acc.func    = FUNC_READ;
        acc.address = 16'($urandom_range(0, 16'h7FFF));
      end
      5, 6: acc.address = 16'($urandom_range(16'hA000, 16'hBFFF));
      7:    acc.address = 16'($urandom_range(ADDR_ECHO_LO, ADDR_ECHO_HI - 1));
      8, 9: acc.address = 16'($urandom_range(16'hFE00, 16'hFFFF));
      10: begin
        case ($urandom_range(0, 3))
          0: acc.address = ADDR_LY;
          1: acc.address = ADDR_DIV;
          2: acc.address = ADDR_DMA;
          default: acc.address = ADDR_TAC;
        endcase
      end
      11: acc.address = EDGE_ADDRS[$urandom_range(0, 15)];
      default: ;
    endcase
    return acc;
  endfunction

  // Drive the result channel's ready
  always @(posedge clk) begin
    result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) begin
      observed.target         = result_ch.target;
      observed.phys_address   = result_ch.phys_address;
      observed.store_byte     = result_ch.store_byte;
      observed.mirror_write   = result_ch.mirror_write;
      observed.mirror_address = result_ch.mirror_address;
      observed.ram_gate_open  = result_ch.ram_gate_open;
      result_count++;
      if (pending_decodes.size() == 0) begin
        if (mismatch_count < 10)
          $display("[%0d] result with no prediction: tgt=%0d phys=%h byte=%h mir=%b/%h gate=%b",
                   cycle_count, observed.target, observed.phys_address, observed.store_byte,
                   observed.mirror_write, observed.mirror_address, observed.ram_gate_open);
        mismatch_count++;
      end else begin
        predicted = pending_decodes.pop_front();
        if (observed.target !== predicted.target ||
            observed.phys_address !== predicted.phys_address ||
            observed.store_byte !== predicted.store_byte ||
            observed.mirror_write !== predicted.mirror_write ||
            observed.mirror_address !== predicted.mirror_address ||
            observed.ram_gate_open !== predicted.ram_gate_open) begin
          if (mismatch_count < 10) begin
            $display("[%0d] mismatch on result %0d", cycle_count, result_count);
            $display("  exp tgt=%0d phys=%h byte=%h mir=%b/%h gate=%b",
                     predicted.target, predicted.phys_address, predicted.store_byte,
                     predicted.mirror_write, predicted.mirror_address,
                     predicted.ram_gate_open);
            $display("  got tgt=%0d phys=%h byte=%h mir=%b/%h gate=%b",
                     observed.target, observed.phys_address, observed.store_byte,
                     observed.mirror_write, observed.mirror_address,
                     observed.ram_gate_open);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("banked_memory_map_decoder_top regression: fail");
      $finish;
    end
  end

  // Reads straight after reset: bank 1, RAM bank 0, gate closed
  task automatic test_reset_state();
    send_access(FUNC_READ, 16'h0000, 8'hFF);
    send_access(FUNC_READ, 16'h3FFF, 8'h00);
    send_access(FUNC_READ, 16'h4000, 8'h00);
    send_access(FUNC_READ, 16'hA000, 8'h00);
  endtask

  // Bank register writes: zero bank remap, upper field in both modes, gate key
  task automatic test_bank_registers();
    send_access(FUNC_WRITE, 16'h2000, 8'hE0);
    send_access(FUNC_READ,  16'h7FFF, 8'h00);
    send_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
    send_access(FUNC_WRITE, 16'h4000, 8'hFF);
    send_access(FUNC_READ,  16'h7FFF, 8'h00);
    send_access(FUNC_WRITE, 16'h6000, 8'h01);
    send_access(FUNC_WRITE, 16'h5FFF, 8'h03);
    send_access(FUNC_WRITE, 16'hBFFF, 8'hA5);
    send_access(FUNC_WRITE, 16'h7FFF, 8'hFE);
    send_access(FUNC_WRITE, 16'h1FFF, 8'hFA);
    send_access(FUNC_WRITE, 16'h0000, 8'h0B);
  endtask

  // Echo, unusable area, register resets, DMA and timer writes
  task automatic test_special_writes();
    send_access(FUNC_WRITE, 16'hE000, 8'h11);
    send_access(FUNC_WRITE, 16'hFDFF, 8'hFF);
    send_access(FUNC_READ,  16'hFDFF, 8'h00);
    send_access(FUNC_WRITE, 16'hFEA0, 8'h77);
    send_access(FUNC_WRITE, 16'hFEFE, 8'h77);
    send_access(FUNC_WRITE, 16'hFEFF, 8'h77);
    send_access(FUNC_WRITE, 16'hFF44, 8'hFF);
    send_access(FUNC_WRITE, 16'hFF04, 8'hFF);
    send_access(FUNC_WRITE, 16'hFF46, 8'hFF);
    send_access(FUNC_WRITE, 16'hFF07, 8'h05);
    send_access(FUNC_WRITE, 16'hFFFF, 8'h80);
  endtask

  // Random traffic, with idling on both sides unless steady_flow is set
  task automatic test_random_traffic(input int count);
    access_t acc;
    for (int i = 0; i < count; i++) begin
      acc = pick_access();
      send_access(acc.func, acc.address, acc.data_in);
    end
  endtask

  // Back-to-back traffic with no idling anywhere
  task automatic test_steady_stream(input int count);
    steady_flow = 1'b1;
    test_random_traffic(count);
    steady_flow = 1'b0;
  endtask

  // Bursts separated by a full drain of the pipeline
  task automatic test_drain_between_bursts(input int bursts, input int burst_len);
    for (int b = 0; b < bursts; b++) begin
      test_random_traffic(burst_len);
      drain_pending();
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    access_ch.valid   <= 1'b0;
    access_ch.func    <= FUNC_READ;
    access_ch.address <= 16'h0000;
    access_ch.data_in <= 8'h00;
    access_count      = 0;
    write_count       = 0;
    bank_write_count  = 0;
    steady_flow       = 1'b0;
    rom_bank          = ROM_BANK_RESET;
    ram_bank          = 2'd0;
    bank_mode         = 1'b0;
    ram_enabled       = 1'b0;

    // Hold reset, then release it
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_bank_registers();
    test_special_writes();
    test_random_traffic(700);
    test_steady_stream(250);
    test_drain_between_bursts(8, 25);

    // Let the pipeline empty, then settle
    drain_pending();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d accesses (%0d writes, %0d to bank registers), %0d results checked,",
             access_count, write_count, bank_write_count, result_count);
    $display("across idle, back-to-back and drained bursts; %0d mismatches", mismatch_count);
    if (mismatch_count == 0 && pending_decodes.size() == 0) begin
      $display("banked_memory_map_decoder_top regression: pass");
    end else begin
      $display("banked_memory_map_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bmmd_pkg.sv
hdl/bmmd_if.sv
hdl/bmmd_bank_regs.sv
hdl/bmmd_decode.sv
hdl/banked_memory_map_decoder_top.sv
tb/tb_banked_memory_map_decoder_top.sv
